// ===== design/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the fetch slot table with round-robin
// replacement.
// ----------------------------------------------------------------------------
package fst_pkg;

    localparam int SLOTS    = 32;
    localparam int TAG_BITS = 64;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int IN_BITS  = 80;
    localparam int OUT_BITS = 24;

    localparam logic [2:0] FN_LOOKUP = 3'd0;
    localparam logic [2:0] FN_REQ    = 3'd1;
    localparam logic [2:0] FN_THUMB  = 3'd2;
    localparam logic [2:0] FN_LOADED = 3'd3;
    localparam logic [2:0] FN_FAILED = 3'd4;

    typedef struct packed {
        logic failed;
        logic loaded;
        logic thumb;
        logic req;
    } t_flags;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        t_flags              flags;
        logic [7:0]          fmt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_VICTIM,
        ST_FINISH
    } t_state;

endpackage

// ===== design/fst_ram.sv =====
// ----------------------------------------------------------------------------
// fst_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/fetch_slot_table_rr_evict_unit.sv =====
// ----------------------------------------------------------------------------
// fetch_slot_table_rr_evict_unit
// Fully associative fetch slot table with round-robin replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one request beat: a function code and a
//   hashed key with its qualifiers. Master channel (o_m_*) returns exactly
//   one result beat per request.
//   All slot state lives in one RAM (tag, flags, format per slot). A request
//   scans the filled slots one per cycle for a tag match; a mark request
//   that misses takes the next empty slot, or once the table is full, walks
//   one lap from the evict pointer for a slot that is not in flight.
//   The RAM read port, one slot per cycle, paces the tag scan and the victim
//   lap. One request is in progress at a time; the next request is taken
//   the cycle after the result is loaded.
//   Reset empties the table and zeroes the evict pointer; RAM contents are
//   not cleared. A stalled receiver holds the result in the output
//   register; the next request is still accepted and runs up to its
//   result, which then waits until the held beat is taken.
// ----------------------------------------------------------------------------
module fetch_slot_table_rr_evict_unit
    import fst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // func[2:0], key_tag[66:3], key_present[67], path_present[68],
    // load_ok[69], format_code[77:70]
    input  logic [IN_BITS-1:0]  i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // hit[0], allocated[1], refused[2], slot_index[7:3], is_requested[8],
    // is_thumb_requested[9], is_loaded[10], is_failed[11], stored_format[19:12]
    output logic [OUT_BITS-1:0] o_m_tdata
);

    t_state              r_state, n_state;
    logic [2:0]          r_func, n_func;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_key, n_key;
    logic                r_path, n_path;
    logic                r_ok, n_ok;
    logic [7:0]          r_fmt, n_fmt;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]    r_filled, n_filled;
    logic [IDX_W-1:0]    r_evict, n_evict;
    logic [IDX_W-1:0]    r_slot, n_slot;
    t_entry              r_entry, n_entry;
    logic                r_hit, n_hit;
    logic                r_alloc, n_alloc;
    logic                r_refused, n_refused;
    logic                r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0] r_out_data, n_out_data;

    logic                is_mark;
    logic                wr_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_raw;
    t_entry              rd_entry;
    t_entry              upd_entry;
    logic                evictable;
    logic [4:0]          slot_out;

    fst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_slot),
        .i_wr_data(upd_entry),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_raw)
    );

    assign rd_entry  = t_entry'(rd_raw);
    assign is_mark   = r_key && (r_func >= FN_REQ) && (r_func <= FN_FAILED)
                       && !((r_func == FN_LOADED) && !r_path);
    assign evictable = !rd_entry.flags.req || rd_entry.flags.loaded
                       || rd_entry.flags.failed;

    generate
        if (IDX_W >= 5) begin : g_slot_wide
            assign slot_out = r_slot[4:0];
        end else begin : g_slot_narrow
            assign slot_out = {{(5 - IDX_W){1'b0}}, r_slot};
        end
    endgenerate

    always_comb begin
        upd_entry = r_entry;
        if (is_mark) begin
            unique case (r_func)
                FN_REQ:    upd_entry.flags.req    = 1'b1;
                FN_THUMB:  upd_entry.flags.thumb  = 1'b1;
                FN_LOADED: upd_entry.flags.loaded = r_entry.flags.loaded | r_ok;
                FN_FAILED: begin
                    upd_entry.flags.failed = 1'b1;
                    upd_entry.fmt          = r_fmt;
                end
                default: upd_entry = r_entry;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_tag       = r_tag;
        n_key       = r_key;
        n_path      = r_path;
        n_ok        = r_ok;
        n_fmt       = r_fmt;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_filled    = r_filled;
        n_evict     = r_evict;
        n_slot      = r_slot;
        n_entry     = r_entry;
        n_hit       = r_hit;
        n_alloc     = r_alloc;
        n_refused   = r_refused;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        o_s_tready  = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_func    = i_s_tdata[2:0];
                    n_tag     = i_s_tdata[3 +: TAG_BITS];
                    n_key     = i_s_tdata[67];
                    n_path    = i_s_tdata[68];
                    n_ok      = i_s_tdata[69];
                    n_fmt     = i_s_tdata[77:70];
                    n_cnt     = '0;
                    n_hit     = 1'b0;
                    n_alloc   = 1'b0;
                    n_refused = 1'b0;
                    n_state   = i_s_tdata[67] ? ST_MATCH : ST_FINISH;
                end
            end
            ST_MATCH: begin
                rd_addr = r_cnt[IDX_W-1:0];
                if (r_pend && (rd_entry.tag == r_tag)) begin
                    n_slot  = r_pend_idx;
                    n_entry = rd_entry;
                    n_hit   = 1'b1;
                    n_state = ST_FINISH;
                end else if (r_cnt < r_filled) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_cnt[IDX_W-1:0];
                    n_cnt      = r_cnt + 1'b1;
                end else if (!is_mark) begin
                    n_state = ST_FINISH;
                end else if (r_filled < CNT_W'(SLOTS)) begin
                    n_slot   = r_filled[IDX_W-1:0];
                    n_entry  = '{tag: r_tag, flags: '0, fmt: '0};
                    n_hit    = 1'b1;
                    n_alloc  = 1'b1;
                    n_filled = r_filled + 1'b1;
                    n_state  = ST_FINISH;
                end else begin
                    n_idx   = r_evict;
                    n_cnt   = '0;
                    n_state = ST_VICTIM;
                end
            end
            ST_VICTIM: begin
                if (r_pend && evictable) begin
                    n_slot  = r_pend_idx;
                    n_evict = (r_pend_idx == IDX_W'(SLOTS - 1)) ? '0
                                                                : r_pend_idx + 1'b1;
                    n_entry = '{tag: r_tag, flags: '0, fmt: '0};
                    n_hit   = 1'b1;
                    n_alloc = 1'b1;
                    n_state = ST_FINISH;
                end else if (r_cnt < CNT_W'(SLOTS)) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = (r_idx == IDX_W'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                end else begin
                    n_refused = 1'b1;
                    n_state   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    wr_en       = r_hit && is_mark;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[2] = r_refused;
                    if (r_hit) begin
                        n_out_data[0]     = 1'b1;
                        n_out_data[1]     = r_alloc;
                        n_out_data[7:3]   = slot_out;
                        n_out_data[8]     = upd_entry.flags.req;
                        n_out_data[9]     = upd_entry.flags.thumb;
                        n_out_data[10]    = upd_entry.flags.loaded;
                        n_out_data[11]    = upd_entry.flags.failed;
                        n_out_data[19:12] = upd_entry.flags.failed ? upd_entry.fmt : 8'd0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_filled    <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_filled    <= n_filled;
            r_evict     <= n_evict;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_tag      <= n_tag;
        r_key      <= n_key;
        r_path     <= n_path;
        r_ok       <= n_ok;
        r_fmt      <= n_fmt;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_slot     <= n_slot;
        r_entry    <= n_entry;
        r_hit      <= n_hit;
        r_alloc    <= n_alloc;
        r_refused  <= n_refused;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== tb/fetch_slot_table_rr_evict_unit_test.sv =====
// ----------------------------------------------------------------------------
// fetch_slot_table_rr_evict_unit_test
// Self-checking bench for the fetch slot table. Directed requests walk the
// empty-key, no-path, failed-load and spare-code cases. Random episodes then
// fill the table with in-flight slots to force evictions and refusals, and
// settle them again. An in-bench slot table predicts every result beat, and
// both stream sides idle at random.
// ----------------------------------------------------------------------------
module fetch_slot_table_rr_evict_unit_test;
    import fst_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
    localparam int KNOWN_DEPTH  = 48;

    typedef struct packed {
        logic [7:0]          fmt;
        logic                load_ok;
        logic                path;
        logic                key;
        logic [63:0]         tag;
        logic [2:0]          func;
    } fetch_req_t;

    typedef struct packed {
        logic [7:0]          fmt;
        logic                failed;
        logic                loaded;
        logic                thumb;
        logic                req;
        logic [4:0]          slot;
        logic                refused;
        logic                allocated;
        logic                hit;
    } slot_result_t;

    typedef enum int {
        EP_FLOOD,
        EP_SETTLE,
        EP_MIXED
    } episode_t;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // func[2:0], key_tag[66:3], key_present[67], path_present[68],
    // load_ok[69], format_code[77:70]
    logic [IN_BITS-1:0]  i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // hit[0], allocated[1], refused[2], slot_index[7:3], is_requested[8],
    // is_thumb_requested[9], is_loaded[10], is_failed[11], stored_format[19:12]
    logic [OUT_BITS-1:0] o_m_tdata;

    fetch_req_t   pending_req_q[$];
    slot_result_t expected_rsp_q[$];

    logic [TAG_BITS-1:0] tbl_tag   [SLOTS];
    t_flags              tbl_flags [SLOTS];
    logic [7:0]          tbl_fmt   [SLOTS];
    int unsigned         tbl_fill = 0;
    int unsigned         tbl_ptr  = 0;

    int   n_queued    = 0;
    int   n_in_beats  = 0;
    int   n_out_beats = 0;
    int   n_err       = 0;
    int   n_cycles    = 0;
    int   n_hits      = 0;
    int   n_allocs    = 0;
    int   n_evicts    = 0;
    int   n_refused   = 0;
    int   tx_gap      = 0;
    int   rx_stall    = 0;
    logic in_taken    = 1'b0;

    wire calm = ((n_in_beats / 150) % 4) == 3;

    fetch_slot_table_rr_evict_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    function automatic int find_tag(logic [TAG_BITS-1:0] tag);
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_tag[i] == tag) return i;
        end
        return -1;
    endfunction

    function automatic slot_result_t slot_table_step(fetch_req_t r);
        slot_result_t o;
        logic [TAG_BITS-1:0] tag;
        int slot;
        int idx;
        logic mark;
        o    = '0;
        tag  = r.tag[TAG_BITS-1:0];
        if (!r.key) return o;
        mark = (r.func >= FN_REQ) && (r.func <= FN_FAILED)
               && !(r.func == FN_LOADED && !r.path);
        slot = find_tag(tag);
        if (mark && slot < 0) begin
            if (tbl_fill < SLOTS) begin
                slot = tbl_fill;
                tbl_fill++;
            end else begin
                for (int t = 0; t < SLOTS && slot < 0; t++) begin
                    idx = (tbl_ptr + t) % SLOTS;
                    if (!tbl_flags[idx].req || tbl_flags[idx].loaded
                        || tbl_flags[idx].failed) begin
                        slot    = idx;
                        tbl_ptr = (idx + 1) % SLOTS;
                        n_evicts++;
                    end
                end
            end
            if (slot >= 0) begin
                tbl_tag[slot]   = tag;
                tbl_flags[slot] = '0;
                tbl_fmt[slot]   = '0;
                o.allocated     = 1'b1;
                n_allocs++;
            end else begin
                o.refused = 1'b1;
                n_refused++;
            end
        end
        if (mark && slot >= 0) begin
            case (r.func)
                FN_REQ: begin
                    tbl_flags[slot].req = 1'b1;
                end
                FN_THUMB: begin
                    tbl_flags[slot].thumb = 1'b1;
                end
                FN_LOADED: begin
                    if (r.load_ok) tbl_flags[slot].loaded = 1'b1;
                end
                default: begin
                    tbl_flags[slot].failed = 1'b1;
                    tbl_fmt[slot]          = r.fmt;
                end
            endcase
        end
        if (slot >= 0) begin
            o.hit    = 1'b1;
            o.slot   = slot[4:0];
            o.req    = tbl_flags[slot].req;
            o.thumb  = tbl_flags[slot].thumb;
            o.loaded = tbl_flags[slot].loaded;
            o.failed = tbl_flags[slot].failed;
            o.fmt    = tbl_flags[slot].failed ? tbl_fmt[slot] : 8'h00;
            n_hits++;
        end
        return o;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_err++;
        end
    endtask

    // sample both channels: check result beats, predict accepted requests
    always @(posedge i_clk) begin
        slot_result_t got;
        slot_result_t want;
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_out_beats++;
                got = o_m_tdata[$bits(slot_result_t)-1:0];
                if (expected_rsp_q.size() == 0) begin
                    $error("result beat with no request outstanding: %0h", o_m_tdata);
                    n_err++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("allocated", want.allocated, got.allocated);
                    check_field("refused", want.refused, got.refused);
                    check_field("slot_index", want.slot, got.slot);
                    check_field("is_requested", want.req, got.req);
                    check_field("is_thumb_requested", want.thumb, got.thumb);
                    check_field("is_loaded", want.loaded, got.loaded);
                    check_field("is_failed", want.failed, got.failed);
                    check_field("stored_format", want.fmt, got.fmt);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                n_in_beats++;
                expected_rsp_q.push_back(slot_table_step(i_s_tdata[$bits(fetch_req_t)-1:0]));
            end
        end
    end

    // request driver: hold the beat until taken, then gap or advance
    always @(negedge i_clk) begin
        logic               nxt_valid;
        logic [IN_BITS-1:0] nxt_data;
        nxt_valid = i_s_tvalid;
        nxt_data  = i_s_tdata;
        if (i_rst_n && (!i_s_tvalid || in_taken)) begin
            nxt_valid = 1'b0;
            if (tx_gap > 0 && !calm) begin
                tx_gap--;
            end else if (pending_req_q.size() != 0) begin
                nxt_data  = {{(IN_BITS - $bits(fetch_req_t)){1'b0}}, pending_req_q.pop_front()};
                nxt_valid = 1'b1;
                tx_gap    = calm ? 0 : pick_gap();
            end
        end
        i_s_tvalid <= nxt_valid;
        i_s_tdata  <= nxt_data;
    end

    // result receiver: random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (calm) begin
            i_m_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            i_m_tready <= 1'b0;
            rx_stall--;
        end else begin
            i_m_tready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("fetch_slot_table_rr_evict_unit_test failed");
            $finish;
        end
    end

    logic [63:0] known_tags[$];
    int          n_effective = 0;

    function automatic fetch_req_t mk_req(logic [2:0] func, logic [63:0] tag, logic key,
                                          logic path, logic ok, logic [7:0] fmt);
        fetch_req_t r;
        r.func    = func;
        r.tag     = tag;
        r.key     = key;
        r.path    = path;
        r.load_ok = ok;
        r.fmt     = fmt;
        return r;
    endfunction

    function automatic logic [63:0] fresh_tag();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_tag(int pct_known);
        if (known_tags.size() != 0 && $urandom_range(0, 99) < pct_known)
            return known_tags[$urandom_range(0, known_tags.size() - 1)];
        return fresh_tag();
    endfunction

    task automatic queue_req(fetch_req_t r);
        pending_req_q.push_back(r);
        n_queued++;
        if (r.key) begin
            n_effective++;
            known_tags.push_back(r.tag);
            if (known_tags.size() > KNOWN_DEPTH) void'(known_tags.pop_front());
        end
    endtask

    initial begin : stimulus
        fetch_req_t r;
        episode_t   mode;
        int         len;
        int         w;
        logic       first;
        // directed: empty table, empty key, no path, failed load, spare codes
        queue_req(mk_req(FN_LOOKUP, '0, 1'b1, 1'b1, 1'b1, 8'h00));
        queue_req(mk_req(FN_REQ, '1, 1'b0, 1'b1, 1'b1, 8'hFF));
        queue_req(mk_req(FN_REQ, '0, 1'b1, 1'b1, 1'b1, 8'h00));
        queue_req(mk_req(FN_THUMB, '1, 1'b1, 1'b0, 1'b0, 8'hFF));
        queue_req(mk_req(FN_LOADED, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b1, 8'h00));
        queue_req(mk_req(FN_LOADED, '1, 1'b1, 1'b1, 1'b0, 8'h00));
        queue_req(mk_req(FN_LOADED, '0, 1'b1, 1'b1, 1'b1, 8'h00));
        queue_req(mk_req(FN_FAILED, '0, 1'b1, 1'b1, 1'b1, 8'hFF));
        queue_req(mk_req(FN_FAILED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 8'h00));
        queue_req(mk_req(FN_LOADED, '1, 1'b1, 1'b0, 1'b1, 8'hA5));
        for (int f = FN_FAILED + 1; f < 8; f++) begin
            queue_req(mk_req(f[2:0], '0, 1'b1, 1'b1, 1'b1, 8'h5A));
        end
        queue_req(mk_req(FN_LOOKUP, '1, 1'b1, 1'b1, 1'b1, 8'hFF));
        queue_req(mk_req(FN_LOOKUP, '1, 1'b0, 1'b0, 1'b0, 8'h00));
        queue_req(mk_req(FN_REQ, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b1, 8'h3C));
        queue_req(mk_req(FN_THUMB, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0, 8'hC3));

        // random episodes; the first floods the table with in-flight slots
        n_effective = 0;
        first       = 1'b1;
        while (n_effective < RANDOM_ITEMS) begin
            w     = $urandom_range(0, 99);
            mode  = first ? EP_FLOOD : (w < 30) ? EP_FLOOD : (w < 65) ? EP_SETTLE : EP_MIXED;
            len   = first ? 70 : $urandom_range(20, 80);
            first = 1'b0;
            for (int k = 0; k < len; k++) begin
                r = mk_req(3'($urandom_range(0, 7)), pick_tag(70), 1'b1,
                           1'($urandom), 1'($urandom), 8'($urandom));
                case (mode)
                    EP_FLOOD: begin
                        if ($urandom_range(0, 9) != 0) begin
                            r.func = FN_REQ;
                            r.tag  = fresh_tag();
                        end
                    end
                    EP_SETTLE: begin
                        w         = $urandom_range(0, 99);
                        r.func    = (w < 45) ? FN_LOADED : (w < 65) ? FN_FAILED :
                                    (w < 75) ? FN_THUMB : (w < 90) ? FN_LOOKUP : FN_REQ;
                        r.tag     = pick_tag(90);
                        r.key     = $urandom_range(0, 99) < 97;
                        r.path    = $urandom_range(0, 99) < 90;
                        r.load_ok = $urandom_range(0, 99) < 80;
                    end
                    default: begin
                        r.key  = $urandom_range(0, 99) < 90;
                        r.path = $urandom_range(0, 99) < 80;
                    end
                endcase
                queue_req(r);
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_in_beats < n_queued) @(negedge i_clk);
        while (expected_rsp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("ran %0d requests and %0d result beats in %0d cycles",
                 n_in_beats, n_out_beats, n_cycles);
        $display("table saw %0d hits, %0d new slots, %0d evictions, %0d refusals",
                 n_hits, n_allocs, n_evicts, n_refused);
        if (n_err == 0) begin
            $display("fetch_slot_table_rr_evict_unit_test passed");
        end else begin
            $display("fetch_slot_table_rr_evict_unit_test failed");
        end
        $finish;
    end

endmodule
